/* rtl/core/rdfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdfc_pkg
// Shared constants, lookup tables and control types for the rgb duty fader.
// ----------------------------------------------------------------------------
package rdfc_pkg;

  localparam int unsigned PeriodUnits  = 10000;
  localparam int unsigned DutyFull     = (PeriodUnits * 1000) / 45;
  localparam int unsigned TickInterval = 50;
  localparam int unsigned StepFull     = (TickInterval * DutyFull) / 5000;
  localparam int unsigned PctMax       = 100;

  localparam int unsigned DutyW = 18;
  localparam int unsigned StepW = 12;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned FrmW  = 6;
  localparam int unsigned NumCh = 3;

  localparam logic [ByteW-1:0] CmdGet    = 8'd71;
  localparam logic [ByteW-1:0] CmdSet    = 8'd80;
  localparam logic [ByteW-1:0] FrameLen  = 8'd6;
  localparam logic [FrmW-1:0]  FrameSize = 6'd6;

  localparam logic [DutyW-1:0] DutyRstRed   = DutyW'(DutyFull);
  localparam logic [DutyW-1:0] DutyRstGreen = DutyW'(DutyFull / 4);
  localparam logic [DutyW-1:0] DutyRstBlue  = DutyW'(DutyFull / 2);
  localparam logic [PctW-1:0]  StepPctRst   = PctW'(PctMax);
  localparam logic [PctW-1:0]  TgtPctRst    = '0;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 88;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MSG  = 1'b1
  } op_e;

  typedef struct packed {
    logic tick;
    logic set;
    logic status;
  } rdfc_ctrl_t;

  typedef logic [StepW-1:0] step_lut_t [0:PctMax];
  typedef logic [DutyW-1:0] tgt_lut_t  [0:PctMax];
  typedef logic [PctW-1:0]  rpt_lut_t  [0:PctMax];

  function automatic step_lut_t build_step_lut();
    step_lut_t lut;
    for (int i = 0; i <= PctMax; i++) begin
      lut[i] = StepW'((i * StepFull) / PctMax);
    end
    return lut;
  endfunction

  function automatic tgt_lut_t build_tgt_lut();
    tgt_lut_t lut;
    for (int i = 0; i <= PctMax; i++) begin
      lut[i] = DutyW'((i * DutyFull) / PctMax);
    end
    return lut;
  endfunction

  function automatic rpt_lut_t build_step_rpt();
    rpt_lut_t lut;
    for (int i = 0; i <= PctMax; i++) begin
      lut[i] = PctW'((((i * StepFull) / PctMax) * PctMax) / StepFull);
    end
    return lut;
  endfunction

  function automatic rpt_lut_t build_tgt_rpt();
    rpt_lut_t lut;
    longint unsigned t;
    for (int i = 0; i <= PctMax; i++) begin
      t = (longint'(i) * DutyFull) / PctMax;
      lut[i] = PctW'((t * PctMax) / DutyFull);
    end
    return lut;
  endfunction

  localparam step_lut_t StepLut = build_step_lut();
  localparam tgt_lut_t  TgtLut  = build_tgt_lut();
  localparam rpt_lut_t  StepRpt = build_step_rpt();
  localparam rpt_lut_t  TgtRpt  = build_tgt_rpt();

endpackage
`default_nettype wire

/* rtl/core/rdfc_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdfc_decode
// Command decode and percentage saturation for one registered input beat.
// ----------------------------------------------------------------------------
module rdfc_decode (
  input  wire                                          op_i,
  input  wire  [rdfc_pkg::FrmW-1:0]                    frame_bytes_i,
  input  wire  [rdfc_pkg::ByteW-1:0]                   length_byte_i,
  input  wire  [rdfc_pkg::ByteW-1:0]                   command_i,
  input  wire  [rdfc_pkg::ByteW-1:0]                   step_pct_i,
  input  wire  [rdfc_pkg::NumCh-1:0][rdfc_pkg::ByteW-1:0] tgt_pct_i,
  output rdfc_pkg::rdfc_ctrl_t                         ctrl_o,
  output logic [rdfc_pkg::PctW-1:0]                    step_pct_o,
  output logic [rdfc_pkg::NumCh-1:0][rdfc_pkg::PctW-1:0]  tgt_pct_o
);
  import rdfc_pkg::*;

  function automatic logic [PctW-1:0] sat_pct(input logic [ByteW-1:0] v);
    return (v > ByteW'(PctMax)) ? PctW'(PctMax) : v[PctW-1:0];
  endfunction

  logic frame_ok;
  logic is_get;
  logic is_set;

  assign frame_ok = (op_e'(op_i) == OP_MSG) && (frame_bytes_i == FrameSize);
  assign is_get   = frame_ok && (command_i == CmdGet);
  assign is_set   = frame_ok && (command_i == CmdSet) && (length_byte_i == FrameLen);

  always_comb begin
    ctrl_o.tick   = (op_e'(op_i) == OP_TICK);
    ctrl_o.set    = is_set;
    ctrl_o.status = is_get || is_set;
  end

  assign step_pct_o = sat_pct(step_pct_i);

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      tgt_pct_o[c] = sat_pct(tgt_pct_i[c]);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rdfc_fade.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdfc_fade
// One fade step of a single channel duty toward its target, with clamping.
// ----------------------------------------------------------------------------
module rdfc_fade (
  input  wire  [rdfc_pkg::DutyW-1:0] duty_i,
  input  wire  [rdfc_pkg::DutyW-1:0] target_i,
  input  wire  [rdfc_pkg::StepW-1:0] step_i,
  input  wire                        up_i,
  output logic [rdfc_pkg::DutyW-1:0] duty_o
);
  import rdfc_pkg::*;

  logic [DutyW:0]   up_sum;
  logic [DutyW-1:0] dn_diff;
  logic             below_step;

  assign up_sum     = {1'b0, duty_i} + (DutyW+1)'(step_i);
  assign below_step = duty_i < DutyW'(step_i);
  assign dn_diff    = duty_i - DutyW'(step_i);

  always_comb begin
    if (up_i) begin
      duty_o = (up_sum >= {1'b0, target_i}) ? target_i : up_sum[DutyW-1:0];
    end else if (below_step) begin
      // subtraction would wrap below zero
      duty_o = target_i;
    end else begin
      duty_o = (dn_diff <= target_i) ? target_i : dn_diff;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rgb_duty_fade_controller_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_duty_fade_controller_unit
// Three-channel led duty fader with a get/set command front end.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis takes one beat per item: tuser = op (0 tick,
//   1 command message), tdata = frame fields. Master channel m_axis gives
//   exactly one beat per item: tuser = kind (0 duty update, 1 response),
//   tdata = status, the four reported percentages and the three duties.
//   An accepted beat lands in the input register; decode, table lookup and
//   fade logic then feed the state and result registers, which load together.
//   Throughput is one item per cycle while the receiver does not stall; the
//   state is updated in the same cycle the result is formed, so a following
//   item sees it at once.
//   When the receiver stalls, the result register holds its beat and the
//   input register still takes one more beat; s_axis_tready drops only when
//   both are full.
//   After reset the duties are 222222, 55555 and 111111, targets are zero,
//   every channel fades upward and the step is the full 2222.
// ----------------------------------------------------------------------------
module rgb_duty_fade_controller_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_bytes[5:0], length_byte[13:6], command[21:14], step_pct[29:22],
  // red_pct[37:30], green_pct[45:38], blue_pct[53:46], zero pad
  input  wire  [rdfc_pkg::InDataW-1:0]      s_axis_tdata,
  // op[0]
  input  wire                               s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // status[0], report_step_pct[7:1], report_red_pct[14:8],
  // report_green_pct[21:15], report_blue_pct[28:22], red_duty[46:29],
  // green_duty[64:47], blue_duty[82:65], zero pad
  output logic [rdfc_pkg::OutDataW-1:0]     m_axis_tdata,
  // kind[0]
  output logic                              m_axis_tuser
);
  import rdfc_pkg::*;

  // input register
  logic                 in_valid_q;
  logic [InDataW-1:0]   in_data_q;
  logic                 in_op_q;

  // state
  logic [DutyW-1:0]     duty_q   [NumCh];
  logic [DutyW-1:0]     duty_d   [NumCh];
  logic [PctW-1:0]      tpct_q   [NumCh];
  logic [PctW-1:0]      tpct_d   [NumCh];
  logic [NumCh-1:0]     up_q;
  logic [NumCh-1:0]     up_d;
  logic [PctW-1:0]      spct_q;
  logic [PctW-1:0]      spct_d;

  // result register
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic [OutDataW-1:0]  out_data_d;
  logic                 out_kind_q;

  logic                 adv;
  rdfc_ctrl_t           ctrl;
  logic [PctW-1:0]      sat_step;
  logic [NumCh-1:0][PctW-1:0]  sat_tgt;
  logic [NumCh-1:0][ByteW-1:0] req_tgt;
  logic [DutyW-1:0]     faded [NumCh];
  logic [StepW-1:0]     step_size;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_op_q   <= s_axis_tuser;
    end
  end

  assign req_tgt[0] = in_data_q[37:30];
  assign req_tgt[1] = in_data_q[45:38];
  assign req_tgt[2] = in_data_q[53:46];

  rdfc_decode u_decode (
    .op_i          (in_op_q),
    .frame_bytes_i (in_data_q[5:0]),
    .length_byte_i (in_data_q[13:6]),
    .command_i     (in_data_q[21:14]),
    .step_pct_i    (in_data_q[29:22]),
    .tgt_pct_i     (req_tgt),
    .ctrl_o        (ctrl),
    .step_pct_o    (sat_step),
    .tgt_pct_o     (sat_tgt)
  );

  assign step_size = StepLut[spct_q];

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    rdfc_fade u_fade (
      .duty_i   (duty_q[c]),
      .target_i (TgtLut[tpct_q[c]]),
      .step_i   (step_size),
      .up_i     (up_q[c]),
      .duty_o   (faded[c])
    );
  end

  always_comb begin
    spct_d = spct_q;
    up_d   = up_q;
    for (int c = 0; c < NumCh; c++) begin
      duty_d[c] = duty_q[c];
      tpct_d[c] = tpct_q[c];
      if (ctrl.tick) begin
        duty_d[c] = faded[c];
      end
      if (ctrl.set) begin
        // targets grow strictly with the percentage, so compare percentages
        up_d[c]   = sat_tgt[c] > tpct_q[c];
        tpct_d[c] = sat_tgt[c];
      end
    end
    if (ctrl.set) begin
      spct_d = sat_step;
    end
  end

  always_comb begin
    out_data_d         = '0;
    out_data_d[0]      = ctrl.status;
    out_data_d[7:1]    = StepRpt[spct_d];
    out_data_d[14:8]   = TgtRpt[tpct_d[0]];
    out_data_d[21:15]  = TgtRpt[tpct_d[1]];
    out_data_d[28:22]  = TgtRpt[tpct_d[2]];
    out_data_d[46:29]  = duty_d[0];
    out_data_d[64:47]  = duty_d[1];
    out_data_d[82:65]  = duty_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q[0] <= DutyRstRed;
      duty_q[1] <= DutyRstGreen;
      duty_q[2] <= DutyRstBlue;
      for (int c = 0; c < NumCh; c++) begin
        tpct_q[c] <= TgtPctRst;
      end
      up_q   <= '1;
      spct_q <= StepPctRst;
    end else if (adv) begin
      for (int c = 0; c < NumCh; c++) begin
        duty_q[c] <= duty_d[c];
        tpct_q[c] <= tpct_d[c];
      end
      up_q   <= up_d;
      spct_q <= spct_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_kind_q <= in_op_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // duties never leave the full-scale range
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q[0] <= DutyW'(DutyFull) && duty_q[1] <= DutyW'(DutyFull) &&
    duty_q[2] <= DutyW'(DutyFull))
    else $error("duty above full scale");

  // a processed beat always shows up on the output
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("processed beat not presented");

  // only a tick moves a duty
  a_duty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && ctrl.tick) |=> $stable(duty_q[0]) && $stable(duty_q[1]) &&
    $stable(duty_q[2]))
    else $error("duty changed without a tick");

  // a tick result never carries an ok status
  a_tick_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == OP_TICK) |-> !m_axis_tdata[0])
    else $error("tick result with ok status");

endmodule
`default_nettype wire

/* tb/rgb_duty_fade_controller_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_duty_fade_controller_unit_tb
// Self-checking bench for the rgb duty fader. Tick and command beats go in on
// s_axis and are mirrored by a scoreboard that keeps its own copy of the
// duties, targets, fade directions and step. Every m_axis beat is checked
// field by field against the oldest predicted result. Directed frames cover
// saturation, bad frames and unknown commands. Random fade scenes follow,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module rgb_duty_fade_controller_unit_tb;
  import rdfc_pkg::*;

  localparam int unsigned ItemTarget = 1400;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    op_e                  op;
    logic [FrmW-1:0]      frame_bytes;
    logic [ByteW-1:0]     length_byte;
    logic [ByteW-1:0]     command;
    logic [ByteW-1:0]     step_pct;
    logic [2:0][ByteW-1:0] tgt_pct;   // red, green, blue
  } fade_item_t;

  typedef struct packed {
    logic                   kind;
    logic                   status;
    logic [PctW-1:0]        rpt_step;
    logic [2:0][PctW-1:0]   rpt_tgt;
    logic [2:0][DutyW-1:0]  duty;
  } fade_result_t;

  class fade_scoreboard;
    int unsigned  duty[3];
    int unsigned  target[3];
    bit           rising[3];
    int unsigned  step;
    fade_result_t expected_q[$];
    int unsigned  mismatches;
    string        chan[3];

    function new();
      duty[0] = DutyFull;
      duty[1] = DutyFull / 4;
      duty[2] = DutyFull / 2;
      for (int c = 0; c < 3; c++) begin
        target[c] = 0;
        rising[c] = 1'b1;
      end
      step = StepFull;
      mismatches = 0;
      chan[0] = "red";
      chan[1] = "green";
      chan[2] = "blue";
    endfunction

    function int unsigned clip_pct(logic [ByteW-1:0] p);
      return (p > PctMax) ? PctMax : int'(p);
    endfunction

    function void fade_one(int c);
      int unsigned nv;
      if (rising[c]) begin
        nv = duty[c] + step;
        duty[c] = (nv >= target[c]) ? target[c] : nv;
      end else if (duty[c] < step) begin
        // subtraction would wrap, snap straight to the target
        duty[c] = target[c];
      end else begin
        nv = duty[c] - step;
        duty[c] = (nv <= target[c]) ? target[c] : nv;
      end
      duty[c] &= 32'h3FFFF;
    endfunction

    function void note_input(fade_item_t it);
      fade_result_t exp;
      int unsigned  nt;
      exp.status = 1'b0;
      if (it.op == OP_TICK) begin
        for (int c = 0; c < 3; c++) fade_one(c);
      end else if (it.frame_bytes == FrameSize) begin
        if (it.command == CmdGet) begin
          exp.status = 1'b1;
        end else if (it.command == CmdSet && it.length_byte == FrameLen) begin
          step = clip_pct(it.step_pct) * StepFull / PctMax;
          for (int c = 0; c < 3; c++) begin
            nt = clip_pct(it.tgt_pct[c]) * DutyFull / PctMax;
            rising[c] = nt > target[c];
            target[c] = nt;
          end
          exp.status = 1'b1;
        end
      end
      exp.kind = it.op;
      exp.rpt_step = PctW'(step * PctMax / StepFull);
      for (int c = 0; c < 3; c++) begin
        exp.rpt_tgt[c] = PctW'(target[c] * PctMax / DutyFull);
        exp.duty[c] = DutyW'(duty[c]);
      end
      expected_q.push_back(exp);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(fade_result_t got);
      fade_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("kind", exp.kind, got.kind);
      compare_field("status", exp.status, got.status);
      compare_field("report_step_pct", exp.rpt_step, got.rpt_step);
      for (int c = 0; c < 3; c++) begin
        compare_field($sformatf("report_%s_pct", chan[c]), exp.rpt_tgt[c], got.rpt_tgt[c]);
        compare_field($sformatf("%s_duty", chan[c]), exp.duty[c], got.duty[c]);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;

  fade_scoreboard board;
  int unsigned    sent_items = 0;
  int unsigned    send_calm = 0;
  int unsigned    cycles = 0;

  rgb_duty_fade_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [ByteW-1:0] rand_pct();
    return ($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(0, 255))
                                       : ByteW'($urandom_range(0, PctMax));
  endfunction

  // called and returns on a falling edge
  task automatic send_beat(fade_item_t it);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {2'b00, it.tgt_pct[2], it.tgt_pct[1], it.tgt_pct[0], it.step_pct,
                      it.command, it.length_byte, it.frame_bytes};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(it);
    sent_items++;
    @(negedge clk_i);
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_tick();
    fade_item_t it;
    it = fade_item_t'({$urandom, $urandom});
    it.op = OP_TICK;
    send_beat(it);
  endtask

  task automatic send_msg(logic [FrmW-1:0] fb, logic [ByteW-1:0] len, logic [ByteW-1:0] cmd,
                          logic [ByteW-1:0] sp, logic [ByteW-1:0] rp, logic [ByteW-1:0] gp,
                          logic [ByteW-1:0] bp);
    fade_item_t it;
    it.op          = OP_MSG;
    it.frame_bytes = fb;
    it.length_byte = len;
    it.command     = cmd;
    it.step_pct    = sp;
    it.tgt_pct[0]  = rp;
    it.tgt_pct[1]  = gp;
    it.tgt_pct[2]  = bp;
    send_beat(it);
  endtask

  task automatic send_set();
    logic [ByteW-1:0] sp;
    case ($urandom_range(0, 3))
      0: sp = ByteW'($urandom_range(0, 255));
      1: sp = ByteW'($urandom_range(1, 10));
      default: sp = ByteW'($urandom_range(20, PctMax));
    endcase
    send_msg(FrameSize, FrameLen, CmdSet, sp, rand_pct(), rand_pct(), rand_pct());
  endtask

  task automatic send_noise();
    logic [ByteW-1:0] cmd;
    logic [FrmW-1:0]  fb;
    case ($urandom_range(0, 2))
      0: cmd = CmdGet;
      1: cmd = CmdSet;
      default: cmd = ByteW'($urandom_range(0, 255));
    endcase
    fb = ($urandom_range(0, 1) == 0) ? FrameSize : FrmW'($urandom_range(0, 63));
    send_msg(fb, ByteW'($urandom_range(0, 255)), cmd, ByteW'($urandom_range(0, 255)),
             ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
             ByteW'($urandom_range(0, 255)));
  endtask

  // a set followed by a run of ticks lets the duties actually reach targets
  task automatic random_scene();
    int unsigned r;
    int unsigned run;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_set();
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      repeat (run) begin
        if ($urandom_range(0, 19) == 0) begin
          send_msg(FrameSize, ByteW'($urandom_range(0, 255)), CmdGet, ByteW'($urandom),
                   ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
        end else begin
          send_tick();
        end
      end
    end else if (r < 55) begin
      send_tick();
    end else if (r < 70) begin
      send_msg(FrameSize, ByteW'($urandom_range(0, 255)), CmdGet, ByteW'($urandom),
               ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
    end else begin
      send_noise();
    end
  endtask

  // receiver side: random stalls with calm stretches in between
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm_left > 0) begin
        m_axis_tready <= 1'b1;
        calm_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
        else if ($urandom_range(0, 99) < 35) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(fade_result_t'({m_axis_tuser, m_axis_tdata[0], m_axis_tdata[7:1],
                                         m_axis_tdata[28:22], m_axis_tdata[21:15],
                                         m_axis_tdata[14:8], m_axis_tdata[82:65],
                                         m_axis_tdata[64:47], m_axis_tdata[46:29]}));
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("rgb_duty_fade_controller_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit drained;
    drained = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_TICK;
    board = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset state: upward fade onto a zero target
    send_tick();
    send_msg(FrameSize, 8'd0, CmdGet, 8'd0, 8'd0, 8'd0, 8'd0);
    // saturation above 100
    send_msg(FrameSize, FrameLen, CmdSet, 8'd255, 8'd255, 8'd101, 8'd100);
    send_tick();
    send_tick();
    send_msg(FrameSize, FrameLen, CmdSet, 8'd1, 8'd0, 8'd50, 8'd99);
    send_tick();
    send_tick();
    // zero step freezes the fade
    send_msg(FrameSize, FrameLen, CmdSet, 8'd0, 8'd0, 8'd50, 8'd99);
    send_tick();
    // bad length byte on a set
    send_msg(FrameSize, 8'd5, CmdSet, 8'd10, 8'd10, 8'd10, 8'd10);
    send_msg(FrameSize, 8'd255, CmdSet, 8'd10, 8'd10, 8'd10, 8'd10);
    // wrong frame size
    send_msg(6'd0, FrameLen, CmdGet, 8'd0, 8'd0, 8'd0, 8'd0);
    send_msg(6'd63, FrameLen, CmdSet, 8'd50, 8'd50, 8'd50, 8'd50);
    send_msg(6'd5, FrameLen, CmdGet, 8'd0, 8'd0, 8'd0, 8'd0);
    send_msg(6'd7, FrameLen, CmdSet, 8'd50, 8'd50, 8'd50, 8'd50);
    // unknown command bytes
    send_msg(FrameSize, FrameLen, 8'd0, 8'd50, 8'd50, 8'd50, 8'd50);
    send_msg(FrameSize, FrameLen, 8'd255, 8'd50, 8'd50, 8'd50, 8'd50);
    // full step downward
    send_msg(FrameSize, FrameLen, CmdSet, 8'd100, 8'd100, 8'd0, 8'd37);
    send_tick();
    send_tick();
    send_tick();
    send_msg(FrameSize, FrameLen, CmdSet, 8'd100, 8'd0, 8'd0, 8'd0);
    send_tick();
    send_tick();
    send_tick();
    send_msg(FrameSize, 8'd255, CmdGet, 8'd255, 8'd255, 8'd255, 8'd255);

    while (sent_items < ItemTarget) begin
      if (!drained && sent_items >= ItemTarget / 2) begin
        // hold off until the pipeline has fully emptied
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk_i);
        @(negedge clk_i);
        drained = 1'b1;
      end
      random_scene();
    end
    s_axis_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("rgb_duty_fade_controller_unit verification clean");
    end else begin
      $display("rgb_duty_fade_controller_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
